// ===== design/roc_pkg.sv =====
// shared types, codes and constants of the occupancy grid
package roc_pkg;

  localparam int DEF_MAX_COLUMNS = 64;
  localparam int DEF_MAX_ROWS    = 64;

  // signed coordinate width: covers origin plus size and bounds up to 256
  localparam int COORD_W   = 10;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 7;

  localparam logic [1:0] OP_CHECK = 2'd0;
  localparam logic [1:0] OP_MARK  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 8'd1;

  localparam logic [CFG_DAT_W-1:0] RESET_COLUMNS = 7'd64;
  localparam logic [CFG_DAT_W-1:0] RESET_ROWS    = 7'd64;

  localparam logic signed [16:0] EMPTY_ID = -17'sd1;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic        occ;
    logic [15:0] tag;
    logic [9:0]  spr_w;
    logic [9:0]  spr_h;
    logic [15:0] uid;
  } cell_t;

  typedef struct packed {
    logic  en;
    cell_t data;
  } mem_wr_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_START,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

endpackage

// ===== design/roc_in_if.sv =====
// request channel of the occupancy grid
interface roc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [7:0]  pos_x;
  logic signed [7:0]  pos_y;
  logic [6:0]         rect_width;
  logic [6:0]         rect_height;
  logic               object_layer;
  logic               occupied_flag;
  logic [15:0]        sprite_tag;
  logic [9:0]         sprite_width;
  logic [9:0]         sprite_height;
  logic [15:0]        unique_id_in;

  modport source (
    output valid, operation, pos_x, pos_y, rect_width, rect_height, object_layer,
           occupied_flag, sprite_tag, sprite_width, sprite_height, unique_id_in,
    input  ready
  );
  modport sink (
    input  valid, operation, pos_x, pos_y, rect_width, rect_height, object_layer,
           occupied_flag, sprite_tag, sprite_width, sprite_height, unique_id_in,
    output ready
  );
endinterface

// ===== design/roc_out_if.sv =====
// result channel of the occupancy grid
interface roc_out_if;
  logic               valid;
  logic               ready;
  logic               fits;
  logic               cell_occupied;
  logic [15:0]        cell_tag;
  logic [9:0]         cell_sprite_width;
  logic [9:0]         cell_sprite_height;
  logic signed [16:0] cell_unique_id;

  modport source (
    output valid, fits, cell_occupied, cell_tag, cell_sprite_width, cell_sprite_height,
           cell_unique_id,
    input  ready
  );
  modport sink (
    input  valid, fits, cell_occupied, cell_tag, cell_sprite_width, cell_sprite_height,
           cell_unique_id,
    output ready
  );
endinterface

// ===== design/roc_cfg_if.sv =====
// configuration write channel of the occupancy grid
interface roc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] reg_index;
  logic [6:0] data;

  modport source (output valid, reg_index, data, input ready);
  modport sink (input valid, reg_index, data, output ready);
endinterface

// ===== design/roc_layer_mem.sv =====
// one grid layer: single write port, registered read port
module roc_layer_mem #(
  parameter int DEPTH = roc_pkg::DEF_MAX_COLUMNS * roc_pkg::DEF_MAX_ROWS,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  roc_pkg::mem_wr_t  wr,
  input  logic [AW-1:0]     wr_addr,
  input  logic [AW-1:0]     rd_addr,
  output roc_pkg::cell_t    rd_data_r
);
  import roc_pkg::*;

  cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

endmodule

// ===== design/rect_occupancy_grid_core.sv =====
// two-layer rectangle occupancy grid: check, mark and read operations
//
// Terrain and object cells live in two memories of MAX_COLUMNS*MAX_ROWS
// entries, each with one write port and one registered read port, and one cell
// of one layer is visited per cycle. After reset a clearing pass writes every
// entry of both layers; no request is taken in that time, configuration
// writes are. One request is worked on at a time. A check of a w x h
// rectangle stops early at the first occupied cell, a mark of a w x h
// rectangle is clipped to the grid, and an empty rectangle, a rectangle off
// the grid or a read off the grid is answered without a scan. The scan rate
// is set by the one memory access per cycle of the layer port. A finished
// result waits in the output register while the next request is taken; that
// request is taken at the earliest at the edge of the result transaction.
module rect_occupancy_grid_core #(
  parameter int MAX_COLUMNS = roc_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = roc_pkg::DEF_MAX_ROWS
) (
  input logic         clk,
  input logic         rst_n,
  roc_in_if.sink      in_ch,
  roc_out_if.source   out_ch,
  roc_cfg_if.sink     cfg_ch
);
  import roc_pkg::*;

  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XBW   = $clog2(MAX_COLUMNS + 1);
  localparam int YBW   = $clog2(MAX_ROWS + 1);

  state_t state_r, state_nxt;

  logic [CFG_DAT_W-1:0] cols_r, rows_r;
  logic [AW-1:0]        clr_addr_r;

  // latched request
  logic [1:0]        op_r;
  logic signed [7:0] px_r, py_r;
  logic [6:0]        rw_r, rh_r;
  logic              layer_r;
  cell_t             word_r;

  // clipped scan region
  logic [XBW-1:0] x0_r, x1_r, x_r;
  logic [YBW-1:0] y0_r, y1_r, y_r;
  logic           nonempty_r, empty_rect_r, inside_r;
  logic [AW-1:0]  addr_r, col_base_r;
  logic           rd_pend_r;

  // working result and output register
  logic  fits_r;
  cell_t res_cell_r;
  logic  out_valid_r;
  logic  out_fits_r;
  cell_t out_cell_r;

  mem_wr_t       ter_wr, obj_wr;
  logic [AW-1:0] wr_addr;
  cell_t         ter_rd, obj_rd, rd_cell;

  logic scan_last, scan_hit, out_load;

  coord_t bx, by, pxe, pye, xe, ye, cx0, cx1, cy0, cy1;

  roc_layer_mem #(.DEPTH(DEPTH), .AW(AW)) u_terrain (
    .clk       (clk),
    .wr        (ter_wr),
    .wr_addr   (wr_addr),
    .rd_addr   (addr_r),
    .rd_data_r (ter_rd)
  );

  roc_layer_mem #(.DEPTH(DEPTH), .AW(AW)) u_object (
    .clk       (clk),
    .wr        (obj_wr),
    .wr_addr   (wr_addr),
    .rd_addr   (addr_r),
    .rd_data_r (obj_rd)
  );

  assign rd_cell = layer_r ? obj_rd : ter_rd;

  // bounds saturate at the storage size
  always_comb begin
    bx = ({3'b000, cols_r} > 10'(MAX_COLUMNS)) ? coord_t'(MAX_COLUMNS)
                                               : coord_t'({3'b000, cols_r});
    by = ({3'b000, rows_r} > 10'(MAX_ROWS)) ? coord_t'(MAX_ROWS)
                                            : coord_t'({3'b000, rows_r});
    pxe = coord_t'(px_r);
    pye = coord_t'(py_r);
    xe  = pxe + coord_t'({3'b000, rw_r});
    ye  = pye + coord_t'({3'b000, rh_r});
    cx0 = (pxe < 0) ? coord_t'(0) : pxe;
    cy0 = (pye < 0) ? coord_t'(0) : pye;
    cx1 = (xe < bx) ? xe : bx;
    cy1 = (ye < by) ? ye : by;
  end

  assign scan_last = ((y_r + YBW'(1)) == y1_r) && ((x_r + XBW'(1)) == x1_r);
  assign scan_hit  = (op_r == OP_CHECK) && rd_pend_r && rd_cell.occ;
  assign out_load  = (state_r == ST_FINISH) && (!out_valid_r || out_ch.ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_ch.valid) state_nxt = ST_SETUP;
      end
      ST_SETUP: state_nxt = ST_START;
      ST_START: begin
        unique case (op_r) inside
          OP_CHECK: state_nxt = (empty_rect_r || !inside_r) ? ST_FINISH : ST_RUN;
          OP_MARK, OP_READ: state_nxt = nonempty_r ? ST_RUN : ST_FINISH;
          default: state_nxt = ST_FINISH;
        endcase
      end
      ST_RUN: begin
        if (scan_hit) begin
          state_nxt = ST_FINISH;
        end else if (scan_last) begin
          state_nxt = (op_r == OP_MARK) ? ST_FINISH : ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // memory controls
  always_comb begin
    ter_wr  = '0;
    obj_wr  = '0;
    wr_addr = addr_r;
    unique case (state_r)
      ST_CLEAR: begin
        ter_wr.en = 1'b1;
        obj_wr.en = 1'b1;
        wr_addr   = clr_addr_r;
      end
      ST_RUN: begin
        ter_wr.data = word_r;
        obj_wr.data = word_r;
        ter_wr.en   = (op_r == OP_MARK) && !layer_r;
        obj_wr.en   = (op_r == OP_MARK) && layer_r;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      cols_r      <= RESET_COLUMNS;
      rows_r      <= RESET_ROWS;
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= (state_r == ST_RUN) && (op_r != OP_MARK);
      if (state_r == ST_CLEAR) clr_addr_r <= AW'(clr_addr_r + AW'(1));
      if (cfg_ch.valid) begin
        unique case (cfg_ch.reg_index)
          CFG_GRID_COLUMNS: cols_r <= cfg_ch.data;
          CFG_GRID_ROWS:    rows_r <= cfg_ch.data;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request, scan and result payload
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        op_r    <= in_ch.operation;
        px_r    <= in_ch.pos_x;
        py_r    <= in_ch.pos_y;
        layer_r <= in_ch.object_layer;
        // a read is a one-cell rectangle
        rw_r    <= (in_ch.operation == OP_READ) ? 7'd1 : in_ch.rect_width;
        rh_r    <= (in_ch.operation == OP_READ) ? 7'd1 : in_ch.rect_height;
        word_r  <= in_ch.occupied_flag
                   ? cell_t'{occ: 1'b1, tag: in_ch.sprite_tag, spr_w: in_ch.sprite_width,
                             spr_h: in_ch.sprite_height, uid: in_ch.unique_id_in}
                   : cell_t'('0);
        fits_r     <= 1'b0;
        res_cell_r <= '0;
      end
      ST_SETUP: begin
        x0_r         <= XBW'(cx0);
        x1_r         <= XBW'(cx1);
        y0_r         <= YBW'(cy0);
        y1_r         <= YBW'(cy1);
        nonempty_r   <= (cx0 < cx1) && (cy0 < cy1);
        empty_rect_r <= (rw_r == 7'd0) || (rh_r == 7'd0);
        inside_r     <= (pxe >= 0) && (pye >= 0) && (xe <= bx) && (ye <= by);
      end
      ST_START: begin
        x_r        <= x0_r;
        y_r        <= y0_r;
        col_base_r <= AW'(AW'(x0_r) * AW'(MAX_ROWS));
        addr_r     <= AW'(AW'(x0_r) * AW'(MAX_ROWS) + AW'(y0_r));
        if (op_r == OP_CHECK && empty_rect_r) fits_r <= 1'b1;
      end
      ST_RUN: begin
        if ((y_r + YBW'(1)) == y1_r) begin
          x_r        <= XBW'(x_r + XBW'(1));
          y_r        <= y0_r;
          col_base_r <= AW'(col_base_r + AW'(MAX_ROWS));
          addr_r     <= AW'(col_base_r + AW'(MAX_ROWS) + AW'(y0_r));
        end else begin
          y_r    <= YBW'(y_r + YBW'(1));
          addr_r <= AW'(addr_r + AW'(1));
        end
      end
      ST_DRAIN: begin
        if (op_r == OP_CHECK) fits_r <= !rd_cell.occ;
        if (op_r == OP_READ) res_cell_r <= rd_cell;
      end
      default: ;
    endcase
    if (out_load) begin
      out_fits_r <= fits_r;
      out_cell_r <= res_cell_r;
    end
  end

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid              = out_valid_r;
  assign out_ch.fits               = out_fits_r;
  assign out_ch.cell_occupied      = out_cell_r.occ;
  assign out_ch.cell_tag           = out_cell_r.occ ? out_cell_r.tag : 16'd0;
  assign out_ch.cell_sprite_width  = out_cell_r.occ ? out_cell_r.spr_w : 10'd0;
  assign out_ch.cell_sprite_height = out_cell_r.occ ? out_cell_r.spr_h : 10'd0;
  assign out_ch.cell_unique_id     = out_cell_r.occ ? $signed({1'b0, out_cell_r.uid})
                                                    : EMPTY_ID;

endmodule
